// ----- hdl/hlbc_pkg.sv -----
package hlbc_pkg;

    localparam int BUFFERS   = 32;
    localparam int BUCKETS   = 13;
    localparam int IDX_W     = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLS_W     = BKT_W + 1;
    localparam int BLK_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 8;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // bucket of a block number: fold the upper half in, then divide by reciprocal
    localparam int HALF_W    = BLK_W / 2;
    localparam int HALF_MOD  = (1 << HALF_W) % BUCKETS;
    localparam int SUM_W     = HALF_W + BKT_W;
    localparam int RECIP_SH  = SUM_W + BKT_W;
    localparam int PROD_W    = SUM_W + RECIP_SH + 1;
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH + 1)'(((64'd1 << RECIP_SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));
    localparam int MOD_STEPS = 3;
    localparam int STEP_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
        logic [BKT_W-1:0]  home;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

endpackage

// ----- hdl/hlbc_if.sv -----
interface hlbc_req_if import hlbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] buffer_slot_in;
    logic [TIME_W-1:0] now_ticks;

    modport source (output valid, output op, output block_number, output buffer_slot_in,
                    output now_ticks, input ready);
    modport sink   (input valid, input op, input block_number, input buffer_slot_in,
                    input now_ticks, output ready);
endinterface

interface hlbc_rsp_if import hlbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] buffer_slot;
    logic              hit;
    logic              needs_fill;
    logic              no_free;
    logic              count_error;

    modport source (output valid, output buffer_slot, output hit, output needs_fill,
                    output no_free, output count_error, input ready);
    modport sink   (input valid, input buffer_slot, input hit, input needs_fill,
                    input no_free, input count_error, output ready);
endinterface

// ----- hdl/hlbc_front.sv -----
module hlbc_front import hlbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hlbc_req_if.sink   req,
    output logic       push,
    output q_item_t    push_item,
    input  q_stat_t    stat
);

    front_state_t         state_reg, state_next;
    q_item_t              item_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [BKT_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     quo_next;
    logic [SUM_W-1:0]     rem_full;
    logic                 accept;

    // blk = hi * 2^HALF_W + lo, and 2^HALF_W is HALF_MOD modulo BUCKETS
    assign sum_next = SUM_W'(item_reg.blk[BLK_W-1:HALF_W]) * SUM_W'(HALF_MOD)
                      + SUM_W'(item_reg.blk[HALF_W-1:0]);
    // quotient by reciprocal multiplication, exact for every sum below 2^SUM_W
    assign prod     = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign quo_next = SUM_W'(prod >> RECIP_SH);
    assign rem_full = sum_reg - quo_reg * SUM_W'(BUCKETS);

    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op_t'(req.op) == OP_GET) ? F_MOD : F_PUSH;
                end
            end
            F_MOD:
            begin
                if (step_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            F_IDLE:  req.ready = 1'b1;
            F_MOD:   ;
            F_PUSH:  push = !stat.full;
            default: ;
        endcase
    end

    always_comb
    begin
        push_item      = item_reg;
        push_item.home = rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
        begin
            item_reg.op   <= op_t'(req.op);
            item_reg.blk  <= req.block_number;
            item_reg.slot <= req.buffer_slot_in;
            item_reg.now  <= req.now_ticks;
            item_reg.home <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
        end
        else if (state_reg == F_MOD)
        begin
            // sum, quotient and remainder settle one step apart
            sum_reg  <= sum_next;
            quo_reg  <= quo_next;
            rem_reg  <= BKT_W'(rem_full);
            step_reg <= step_reg + STEP_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.op == OP_GET) |-> (push_item.home < BKT_W'(BUCKETS)))
        else $error("home bucket out of range");
`endif

endmodule

// ----- hdl/hlbc_queue.sv -----
module hlbc_queue import hlbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output q_item_t pop_item,
    output q_stat_t stat
);

    q_item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ----- hdl/hlbc_back.sv -----
module hlbc_back import hlbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    output logic       pop,
    input  q_item_t    pop_item,
    input  q_stat_t    stat,
    hlbc_rsp_if.source rsp
);

    back_state_t        state_reg, state_next;
    q_item_t            cur_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [BLK_W-1:0]   tag_reg   [BUFFERS];
    logic [BKT_W-1:0]   bkt_reg   [BUFFERS];
    logic               valid_reg [BUFFERS];
    logic [CNT_W-1:0]   cnt_reg   [BUFFERS];
    logic [TIME_W-1:0]  time_reg  [BUFFERS];

    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic               pick_v_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic [CLS_W-1:0]   pick_cls_reg;
    logic [TIME_W-1:0]  pick_time_reg;

    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_hit_reg;
    logic               out_fill_reg;
    logic               out_nofree_reg;
    logic               out_err_reg;

    logic [IDX_W-1:0]   slot_idx;
    logic               slot_ok;
    logic [IDX_W-1:0]   rd_idx;
    logic [BLK_W-1:0]   e_tag;
    logic [BKT_W-1:0]   e_bkt;
    logic               e_valid;
    logic [CNT_W-1:0]   e_cnt;
    logic [TIME_W-1:0]  e_time;
    logic [CLS_W-1:0]   e_cls;
    logic               e_hit;
    logic               e_better;
    logic               out_free;
    logic               commit;

    logic [SLOT_W-1:0]  res_slot;
    logic               res_hit;
    logic               res_fill;
    logic               res_nofree;
    logic               res_err;
    logic [IDX_W-1:0]   wr_idx;
    logic               wr_tag_en;
    logic               wr_cnt_en;
    logic [CNT_W-1:0]   wr_cnt;
    logic               wr_time_en;

    assign slot_idx = IDX_W'(cur_reg.slot);
    assign slot_ok  = (32'(cur_reg.slot) < 32'(BUFFERS));
    assign rd_idx   = (state_reg == B_SCAN) ? idx_reg : slot_idx;

    assign e_tag   = tag_reg[rd_idx];
    assign e_bkt   = bkt_reg[rd_idx];
    assign e_valid = valid_reg[rd_idx];
    assign e_cnt   = cnt_reg[rd_idx];
    assign e_time  = time_reg[rd_idx];

    // rank free buffers: home bucket first, then other buckets in ascending order
    assign e_cls    = (e_bkt == cur_reg.home) ? '0 : CLS_W'({1'b0, e_bkt}) + CLS_W'(1);
    assign e_hit    = e_valid && (e_tag == cur_reg.blk);
    assign e_better = (e_cnt == '0) &&
                      (!pick_v_reg || (e_cls < pick_cls_reg) ||
                       ((e_cls == pick_cls_reg) && (e_time < pick_time_reg)));

    assign out_free = !out_valid_reg || rsp.ready;
    assign commit   = (state_reg == B_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = (pop_item.op == OP_GET) ? B_SCAN : B_DONE;
                end
            end
            B_SCAN:
            begin
                if (idx_reg == IDX_W'(BUFFERS - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop = !stat.empty;
            B_SCAN:  ;
            B_DONE:  ;
            default: ;
        endcase
    end

    // result and state update for the transaction in hand
    always_comb
    begin
        res_slot   = '0;
        res_hit    = 1'b0;
        res_fill   = 1'b0;
        res_nofree = 1'b0;
        res_err    = 1'b0;
        wr_idx     = slot_idx;
        wr_tag_en  = 1'b0;
        wr_cnt_en  = 1'b0;
        wr_cnt     = e_cnt;
        wr_time_en = 1'b0;
        unique case (cur_reg.op)
            OP_GET:
            begin
                if (found_reg)
                begin
                    wr_idx    = hit_idx_reg;
                    wr_cnt_en = 1'b1;
                    wr_cnt    = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                : hit_cnt_reg + CNT_W'(1);
                    res_slot  = SLOT_W'(hit_idx_reg);
                    res_hit   = 1'b1;
                end
                else if (pick_v_reg)
                begin
                    wr_idx    = pick_idx_reg;
                    wr_tag_en = 1'b1;
                    wr_cnt_en = 1'b1;
                    wr_cnt    = CNT_W'(1);
                    res_slot  = SLOT_W'(pick_idx_reg);
                    res_fill  = 1'b1;
                end
                else
                begin
                    res_nofree = 1'b1;
                end
            end
            OP_PIN:
            begin
                res_slot = cur_reg.slot;
                if (slot_ok)
                begin
                    wr_cnt_en = 1'b1;
                    wr_cnt    = (e_cnt == COUNT_MAX) ? e_cnt : e_cnt + CNT_W'(1);
                end
            end
            OP_RELEASE, OP_UNPIN:
            begin
                res_slot = cur_reg.slot;
                if (slot_ok)
                begin
                    if (e_cnt == '0)
                    begin
                        res_err = 1'b1;
                    end
                    else
                    begin
                        wr_cnt_en  = 1'b1;
                        wr_cnt     = e_cnt - CNT_W'(1);
                        wr_time_en = (cur_reg.op == OP_RELEASE) && (e_cnt == CNT_W'(1));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BUFFERS; i++)
            begin
                tag_reg[i]   <= '0;
                bkt_reg[i]   <= '0;
                valid_reg[i] <= 1'b0;
                cnt_reg[i]   <= '0;
                time_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (wr_tag_en)
                begin
                    tag_reg[wr_idx]   <= cur_reg.blk;
                    bkt_reg[wr_idx]   <= cur_reg.home;
                    valid_reg[wr_idx] <= 1'b1;
                end
                if (wr_cnt_en)
                begin
                    cnt_reg[wr_idx] <= wr_cnt;
                end
                if (wr_time_en)
                begin
                    time_reg[wr_idx] <= cur_reg.now;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg    <= pop_item;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            pick_v_reg <= 1'b0;
        end
        else if (state_reg == B_SCAN)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            // keep the lowest matching index
            if (!found_reg && e_hit)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= idx_reg;
                hit_cnt_reg <= e_cnt;
            end
            if (e_better)
            begin
                pick_v_reg    <= 1'b1;
                pick_idx_reg  <= idx_reg;
                pick_cls_reg  <= e_cls;
                pick_time_reg <= e_time;
            end
        end
        if (commit)
        begin
            out_slot_reg   <= res_slot;
            out_hit_reg    <= res_hit;
            out_fill_reg   <= res_fill;
            out_nofree_reg <= res_nofree;
            out_err_reg    <= res_err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.buffer_slot = out_slot_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.needs_fill  = out_fill_reg;
    assign rsp.no_free     = out_nofree_reg;
    assign rsp.count_error = out_err_reg;

`ifndef NO_ASSERTIONS
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result loaded outside completion state");
    a_hit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg) |-> (!out_fill_reg && !out_nofree_reg && !out_err_reg))
        else $error("hit combined with another outcome");
    a_nofree_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_nofree_reg) |-> (out_slot_reg == '0 && !out_fill_reg))
        else $error("no_free result carries a buffer");
`endif

endmodule

// ----- hdl/hashed_lru_buffer_cache.sv -----
// Block buffer cache with hashed buckets and least-recently-released replacement.
// req channel: one transaction per operation (get, release, pin, unpin) with
// block_number, buffer_slot_in and now_ticks; rsp channel: exactly one result
// transaction per request, in request order.
// A get first has the front end reduce block_number to its bucket (fold of the
// upper half, reciprocal multiply, subtract); the back end then scans all
// BUFFERS entries, one per cycle, for a hit and for the best free buffer at
// once, and commits once the output register is free. Get throughput is set
// by the back-end scan; the bucket computation of the next get overlaps it
// through a two-entry queue.
// Reset clears all tags, valid bits, counts and release times, so every buffer
// starts invalid, free and in bucket 0.
// When rsp stalls, the finished result is held in the output register, the
// back end holds its next result, the queue fills and then req.ready drops.
module hashed_lru_buffer_cache import hlbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hlbc_req_if.sink   req,
    hlbc_rsp_if.source rsp
);

    logic    push;
    q_item_t push_item;
    logic    pop;
    q_item_t pop_item;
    q_stat_t stat;

    hlbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .push_item (push_item),
        .stat      (stat)
    );

    hlbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (stat)
    );

    hlbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_item (pop_item),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
